>>> sv/pih_pkg.sv
package pih_pkg;

  localparam int MAX_VERTICES = 256;
  localparam int CNT_W = $clog2(MAX_VERTICES + 1);
  localparam int IDX_W = $clog2(MAX_VERTICES);

  localparam logic [1:0] CMD_CLEAR  = 2'd0;
  localparam logic [1:0] CMD_APPEND = 2'd1;
  localparam logic [1:0] CMD_QUERY  = 2'd2;

  typedef struct packed {
    logic [1:0]         cmd;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic [30:0]        radius;
  } in_item_t;

  typedef struct packed {
    logic       inside_res;
    logic       near;
    logic [7:0] nearest_index;
    logic [8:0] vertex_count;
    logic       overflowed;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DRAIN,
    ST_DONE
  } state_t;

  // control that travels with one vertex slot into the evaluation pipeline
  typedef struct packed {
    logic             start;
    logic             edge_ok;
    logic             dist_ok;
    logic [IDX_W-1:0] idx;
  } step_t;

endpackage

>>> sv/pih_cell.sv
module pih_cell import pih_pkg::*; (
  input  logic               clk,
  input  logic               shift_en,
  input  logic signed [31:0] nb_x,
  input  logic signed [31:0] nb_y,
  input  logic               wr_en,
  input  logic signed [31:0] wr_x,
  input  logic signed [31:0] wr_y,
  output logic signed [31:0] x_r,
  output logic signed [31:0] y_r
);

  always_ff @(posedge clk) begin
    if (wr_en) begin
      x_r <= wr_x;
      y_r <= wr_y;
    end else if (shift_en) begin
      x_r <= nb_x;
      y_r <= nb_y;
    end
  end

endmodule

>>> sv/pih_edge_unit.sv
module pih_edge_unit import pih_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  step_t              step,
  input  logic signed [31:0] prev_x,
  input  logic signed [31:0] prev_y,
  input  logic signed [31:0] cur_x,
  input  logic signed [31:0] cur_y,
  input  logic signed [31:0] q_x,
  input  logic signed [31:0] q_y,
  input  logic [30:0]        rad,
  input  logic [61:0]        rad_sq,
  output logic               hits_par_r,
  output logic               found_r,
  output logic [IDX_W-1:0]   best_idx_r
);

  step_t              s1_step_r, s2_step_r;
  logic signed [32:0] s1_ex_r, s1_ey_r, s1_dx_r, s1_dy_r;
  logic [32:0]        s1_ax_r, s1_ay_r;
  logic signed [32:0] ex_nxt, ey_nxt, dx_nxt, dy_nxt, ox, oy;

  logic signed [33:0] s2_den_r, s2_nt_r;
  logic signed [65:0] s2_p1_r, s2_p2_r;
  logic               s2_inr_r;
  logic [61:0]        s2_sqx_r, s2_sqy_r;

  logic signed [66:0] nb;
  logic               dpos, c1, c2, c3, hit, cand;
  logic [62:0]        d2, best_d2_r;

  always_comb begin
    ex_nxt = 33'(cur_x) - 33'(prev_x);
    ey_nxt = 33'(cur_y) - 33'(prev_y);
    dx_nxt = 33'(q_x) - 33'(prev_x);
    dy_nxt = 33'(q_y) - 33'(prev_y);
    ox     = 33'(cur_x) - 33'(q_x);
    oy     = 33'(cur_y) - 33'(q_y);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_step_r <= '0;
      s2_step_r <= '0;
    end else begin
      s1_step_r <= step;
      s2_step_r <= s1_step_r;
    end
  end

  always_ff @(posedge clk) begin
    s1_ex_r <= ex_nxt;
    s1_ey_r <= ey_nxt;
    s1_dx_r <= dx_nxt;
    s1_dy_r <= dy_nxt;
    s1_ax_r <= ox[32] ? 33'(-ox) : 33'(ox);
    s1_ay_r <= oy[32] ? 33'(-oy) : 33'(oy);
    s2_den_r <= 34'(s1_ey_r) - 34'(s1_ex_r);
    s2_nt_r  <= 34'(s1_dy_r) - 34'(s1_dx_r);
    s2_p1_r  <= 66'(s1_dy_r) * 66'(s1_ex_r);
    s2_p2_r  <= 66'(s1_dx_r) * 66'(s1_ey_r);
    s2_inr_r <= (s1_ax_r <= {2'b00, rad}) && (s1_ay_r <= {2'b00, rad});
    s2_sqx_r <= 62'(s1_ax_r[30:0]) * 62'(s1_ax_r[30:0]);
    s2_sqy_r <= 62'(s1_ay_r[30:0]) * 62'(s1_ay_r[30:0]);
  end

  always_comb begin
    nb   = 67'(s2_p1_r) - 67'(s2_p2_r);
    dpos = !s2_den_r[33] && (s2_den_r != '0);
    c1   = (s2_nt_r == '0) || ((!s2_nt_r[33]) == dpos);
    c2   = dpos ? (s2_nt_r < s2_den_r) : (s2_nt_r > s2_den_r);
    c3   = (nb == '0) || ((!nb[66]) == dpos);
    hit  = s2_step_r.edge_ok && (s2_den_r != '0) && c1 && c2 && c3;
    d2   = {1'b0, s2_sqx_r} + {1'b0, s2_sqy_r};
    cand = s2_step_r.dist_ok && s2_inr_r && (d2 <= {1'b0, rad_sq});
  end

  always_ff @(posedge clk) begin
    if (!rst_n || step.start) begin
      hits_par_r <= 1'b0;
      found_r    <= 1'b0;
      best_idx_r <= '0;
      best_d2_r  <= '0;
    end else begin
      hits_par_r <= hits_par_r ^ hit;
      // later vertex wins a tie
      if (cand && (!found_r || d2 <= best_d2_r)) begin
        found_r    <= 1'b1;
        best_idx_r <= s2_step_r.idx;
        best_d2_r  <= d2;
      end
    end
  end

endmodule

>>> sv/polygon_hit_and_vertex_snap.sv
// channel  | ports                         | transaction
// in       | in_valid, in_stall, in_data   | clear, append vertex or query point
// out      | out_valid, out_stall, out_data| one result per query
// Clear and append update the store when accepted. A query takes MAX_VERTICES + 1 ring
// steps (the ring rotates once through all cells, one edge test and one distance compare
// per step, one more step for the closing edge), then drains the evaluation pipeline and
// loads the output register once that register is free.
// Reset empties the store and clears the overflow flag; vertex cells are not reset.
// in_stall is high while a query runs or its result waits for the output register.
module polygon_hit_and_vertex_snap import pih_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data
);

  state_t st_r, st_nxt;
  logic [CNT_W-1:0] step_r, step_nxt, count_r;
  logic             ovf_r, drain_r, drain_nxt;
  logic signed [31:0] q_x_r, q_y_r, prev_x_r, prev_y_r, v0_x_r, v0_y_r;
  logic signed [31:0] cur_x, cur_y;
  logic [30:0]      rad_r;
  logic [61:0]      rsq_r;
  logic             out_valid_r;
  out_item_t        out_r;

  logic signed [31:0] cx [MAX_VERTICES];
  logic signed [31:0] cy [MAX_VERTICES];
  logic             in_acc, shift_en, app_ok, load_out;
  step_t            step;
  logic             hits_par, found;
  logic [IDX_W-1:0] best_idx;

  assign in_acc   = in_valid && !in_stall;
  assign in_stall = (st_r != ST_IDLE);
  assign app_ok   = in_acc && (in_data.cmd == CMD_APPEND) &&
                    (count_r < CNT_W'(MAX_VERTICES));
  assign shift_en = (st_r == ST_RUN) && (step_r < CNT_W'(MAX_VERTICES));

  for (genvar i = 0; i < MAX_VERTICES; i++) begin : g_cell
    pih_cell u_cell (
      .clk     (clk),
      .shift_en(shift_en),
      .nb_x    (cx[(i + 1) % MAX_VERTICES]),
      .nb_y    (cy[(i + 1) % MAX_VERTICES]),
      .wr_en   (app_ok && (count_r[IDX_W-1:0] == IDX_W'(i))),
      .wr_x    (in_data.point_x),
      .wr_y    (in_data.point_y),
      .x_r     (cx[i]),
      .y_r     (cy[i])
    );
  end

  // past the last stored vertex, close the polygon with vertex 0
  always_comb begin
    if (step_r < count_r) begin
      cur_x = cx[0];
      cur_y = cy[0];
    end else begin
      cur_x = v0_x_r;
      cur_y = v0_y_r;
    end
    step.start   = in_acc && (in_data.cmd == CMD_QUERY);
    step.edge_ok = (st_r == ST_RUN) && (step_r != '0) && (step_r <= count_r);
    step.dist_ok = (st_r == ST_RUN) && (step_r < count_r);
    step.idx     = step_r[IDX_W-1:0];
  end

  pih_edge_unit u_edge (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .prev_x    (prev_x_r),
    .prev_y    (prev_y_r),
    .cur_x     (cur_x),
    .cur_y     (cur_y),
    .q_x       (q_x_r),
    .q_y       (q_y_r),
    .rad       (rad_r),
    .rad_sq    (rsq_r),
    .hits_par_r(hits_par),
    .found_r   (found),
    .best_idx_r(best_idx)
  );

  always_comb begin
    st_nxt    = st_r;
    step_nxt  = step_r;
    drain_nxt = drain_r;
    load_out  = 1'b0;
    unique case (st_r)
      ST_IDLE: begin
        if (step.start) begin
          st_nxt   = ST_RUN;
          step_nxt = '0;
        end
      end
      ST_RUN: begin
        step_nxt = step_r + 1'b1;
        if (step_r == CNT_W'(MAX_VERTICES)) begin
          st_nxt    = ST_DRAIN;
          drain_nxt = 1'b0;
        end
      end
      ST_DRAIN: begin
        drain_nxt = 1'b1;
        if (drain_r) st_nxt = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || !out_stall) begin
          load_out = 1'b1;
          st_nxt   = ST_IDLE;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      step_r      <= '0;
      drain_r     <= 1'b0;
      count_r     <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      step_r  <= step_nxt;
      drain_r <= drain_nxt;
      if (in_acc && in_data.cmd == CMD_CLEAR) begin
        count_r <= '0;
        ovf_r   <= 1'b0;
      end else if (in_acc && in_data.cmd == CMD_APPEND) begin
        if (app_ok) count_r <= count_r + 1'b1;
        else        ovf_r   <= 1'b1;
      end
      if (load_out)       out_valid_r <= 1'b1;
      else if (!out_stall) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step.start) begin
      q_x_r <= in_data.point_x;
      q_y_r <= in_data.point_y;
      rad_r <= in_data.radius;
      rsq_r <= 62'(in_data.radius) * 62'(in_data.radius);
    end
    if (st_r == ST_RUN) begin
      prev_x_r <= cur_x;
      prev_y_r <= cur_y;
      if (step_r == '0) begin
        v0_x_r <= cx[0];
        v0_y_r <= cy[0];
      end
    end
    if (load_out) begin
      out_r.inside_res    <= hits_par;
      out_r.near          <= found;
      out_r.nearest_index <= found ? 8'(best_idx) : 8'd0;
      out_r.vertex_count  <= 9'(count_r);
      out_r.overflowed    <= ovf_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  a_count_max: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(MAX_VERTICES))
    else $error("vertex count above capacity");

  a_query_starts: assert property (@(posedge clk) disable iff (!rst_n)
    step.start |=> (st_r == ST_RUN) && (step_r == '0))
    else $error("query did not start the ring walk");

  a_done_loads: assert property (@(posedge clk) disable iff (!rst_n)
    (st_r == ST_DONE) && !(out_valid_r && out_stall) |=> out_valid_r && (st_r == ST_IDLE))
    else $error("finished query result not presented");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
  import pih_pkg::*;

  localparam int IDLE_MAX  = 18;
  localparam int WDOG_LIMIT = 20000;
  localparam int END_WAIT  = 600;
  localparam logic [1:0] CMD_NONE = 2'd3;

  class poly_scoreboard;
    logic signed [31:0] vx[MAX_VERTICES];
    logic signed [31:0] vy[MAX_VERTICES];
    int unsigned        n_stored;
    bit                 ovf;
    out_item_t          pending[$];
    int                 n_errors;

    function void clear_all();
      n_stored = 0;
      ovf      = 0;
      pending.delete();
      n_errors = 0;
    endfunction

    // decide whether the diagonal ray from (px,py) hits edge i
    function bit edge_crossed(int unsigned i, longint px, longint py);
      int unsigned j;
      longint ex, ey, dx, dy, den, nt;
      logic signed [127:0] cr;
      bit dpos;
      j   = (i + 1 >= n_stored) ? 0 : i + 1;
      ex  = longint'(vx[j]) - longint'(vx[i]);
      ey  = longint'(vy[j]) - longint'(vy[i]);
      dx  = px - longint'(vx[i]);
      dy  = py - longint'(vy[i]);
      den = ey - ex;
      nt  = dy - dx;
      if (den == 0) return 0;
      dpos = den > 0;
      cr = 128'(signed'(dy)) * 128'(signed'(ex)) - 128'(signed'(dx)) * 128'(signed'(ey));
      if (!(nt == 0 || ((nt > 0) == dpos))) return 0;
      if (dpos ? !(nt < den) : !(nt > den)) return 0;
      if (!(cr == 0 || ((cr > 0) == dpos))) return 0;
      return 1;
    endfunction

    function void note_transaction(in_item_t t);
      out_item_t r;
      longint px, py, ax, ay;
      longint unsigned d2, best_d2, r2;
      int unsigned hits, best;
      bit found;
      case (t.cmd)
        CMD_CLEAR: begin
          n_stored = 0;
          ovf = 0;
        end
        CMD_APPEND: begin
          if (n_stored >= MAX_VERTICES) ovf = 1;
          else begin
            vx[n_stored] = t.point_x;
            vy[n_stored] = t.point_y;
            n_stored++;
          end
        end
        CMD_QUERY: begin
          px = t.point_x;
          py = t.point_y;
          r2 = longint'(t.radius) * longint'(t.radius);
          hits = 0; best = 0; found = 0; best_d2 = 0;
          for (int unsigned i = 0; i < n_stored; i++) begin
            if (edge_crossed(i, px, py)) hits++;
            ax = longint'(vx[i]) - px; if (ax < 0) ax = -ax;
            ay = longint'(vy[i]) - py; if (ay < 0) ay = -ay;
            if (ax > t.radius || ay > t.radius) continue;
            d2 = ax * ax + ay * ay;
            if (d2 > r2) continue;
            if (!found || d2 <= best_d2) begin
              found = 1; best_d2 = d2; best = i;
            end
          end
          r.inside_res    = hits[0];
          r.near          = found;
          r.nearest_index = found ? best[7:0] : 8'd0;
          r.vertex_count  = n_stored[8:0];
          r.overflowed    = ovf;
          pending.insert(pending.size(), r);
        end
        default: ;
      endcase
    endfunction

    function void check_result(out_item_t got);
      out_item_t e;
      if (pending.size() == 0) begin
        $error("unexpected result %p", got);
        n_errors++;
        return;
      end
      e = pending.pop_front();
      if (got.inside_res !== e.inside_res) begin
        $error("inside_res exp %0d got %0d", e.inside_res, got.inside_res); n_errors++;
      end
      if (got.near !== e.near) begin
        $error("near exp %0d got %0d", e.near, got.near); n_errors++;
      end
      if (got.nearest_index !== e.nearest_index) begin
        $error("nearest_index exp %0d got %0d", e.nearest_index, got.nearest_index);
        n_errors++;
      end
      if (got.vertex_count !== e.vertex_count) begin
        $error("vertex_count exp %0d got %0d", e.vertex_count, got.vertex_count);
        n_errors++;
      end
      if (got.overflowed !== e.overflowed) begin
        $error("overflowed exp %0d got %0d", e.overflowed, got.overflowed); n_errors++;
      end
    endfunction
  endclass

  logic      clk = 0;
  logic      rst_n = 0;
  logic      in_valid = 0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1;
  out_item_t out_data;

  poly_scoreboard sb;
  bit  stim_done = 0;
  bit  hold_out = 0;
  int  idle_cycles = 0;
  int  model_count = 0;   // vertices as the stimulus sees them, for query shaping

  polygon_hit_and_vertex_snap u_top (.*);

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // hold valid through a zero gap; drop it only for an idle stretch
  task automatic send_item(in_item_t t);
    int gap;
    gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, IDLE_MAX);
    @(negedge clk);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_data  <= t;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sb.note_transaction(t);
    if (t.cmd == CMD_CLEAR) model_count = 0;
    if (t.cmd == CMD_APPEND && model_count < MAX_VERTICES) model_count++;
  endtask

  function automatic in_item_t mk(logic [1:0] c, logic signed [31:0] x,
                                  logic signed [31:0] y, logic [30:0] r);
    in_item_t t;
    t.cmd = c; t.point_x = x; t.point_y = y; t.radius = r;
    return t;
  endfunction

  function automatic logic signed [31:0] rnd_coord(int span);
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return 32'sh7fff_ffff;
      2: return 32'sh8000_0000;
      default: return $signed($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  function automatic logic [30:0] rnd_radius();
    case ($urandom_range(0, 5))
      0: return 31'h7fff_ffff;
      1: return 31'($urandom);
      2: return 0;
      default: return 31'($urandom_range(0, 32'h0004_0000));
    endcase
  endfunction

  // receiver: random stall per result, one long hold-off on request
  initial begin
    int w;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_out) begin
        out_stall <= 1;
        w = 0;
        while (w < 2000) begin
          @(negedge clk);
          w++;
        end
        hold_out = 0;
      end
      w = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, IDLE_MAX);
      if (w != 0) begin
        out_stall <= 1;
        repeat (w) @(negedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid && !hold_out);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_result(out_data);
  end

  // watchdog on cycles with no transaction on either channel
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > WDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  initial begin
    int span, nv, k;
    sb = new();
    sb.clear_all();
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    // directed: square, query inside/outside/vertex, extremes, unused command
    send_item(mk(CMD_QUERY, 0, 0, 31'h7fff_ffff));
    send_item(mk(CMD_APPEND, -32'sh10000, -32'sh10000, 0));
    send_item(mk(CMD_APPEND, 32'sh10000, -32'sh10000, 0));
    send_item(mk(CMD_QUERY, 0, 0, 31'h20000));
    send_item(mk(CMD_APPEND, 32'sh10000, 32'sh10000, 0));
    send_item(mk(CMD_APPEND, -32'sh10000, 32'sh10000, 0));
    send_item(mk(CMD_QUERY, 0, 0, 31'h20000));
    send_item(mk(CMD_QUERY, 32'sh10000, 32'sh10000, 0));
    send_item(mk(CMD_QUERY, 0, 0, 31'h16a09));
    send_item(mk(CMD_QUERY, 32'sh30000, 0, 31'h7fff_ffff));
    send_item(mk(CMD_NONE, 32'sh7fff_ffff, 32'sh8000_0000, 31'h7fff_ffff));
    send_item(mk(CMD_APPEND, 32'sh7fff_ffff, 32'sh8000_0000, 31'h7fff_ffff));
    send_item(mk(CMD_APPEND, 32'sh8000_0000, 32'sh7fff_ffff, 0));
    send_item(mk(CMD_QUERY, 32'sh8000_0000, 32'sh8000_0000, 31'h7fff_ffff));
    send_item(mk(CMD_QUERY, 32'sh7fff_ffff, 32'sh7fff_ffff, 31'h7fff_ffff));
    send_item(mk(CMD_QUERY, -1, -1, 31'h7fff_ffff));
    // fill to capacity and past it
    for (int i = model_count; i < MAX_VERTICES + 2; i++)
      send_item(mk(CMD_APPEND, rnd_coord(32'h40000), rnd_coord(32'h40000), 31'($urandom)));
    send_item(mk(CMD_QUERY, 0, 0, 31'h7fff_ffff));
    hold_out = 1;
    send_item(mk(CMD_QUERY, 32'sh8000, -32'sh8000, 31'h30000));
    send_item(mk(CMD_QUERY, 0, 0, 31'h10000));
    send_item(mk(CMD_QUERY, 1, 2, 0));
    send_item(mk(CMD_CLEAR, $urandom, $urandom, 31'($urandom)));
    send_item(mk(CMD_QUERY, 0, 0, 31'h7fff_ffff));

    // random polygons: small ones mostly, a large one now and then
    k = 0;
    while (k < 110) begin
      span = ($urandom_range(0, 3) == 0) ? 32'h7fff_0000 : 32'h0004_0000;
      send_item(mk(CMD_CLEAR, $urandom, $urandom, 31'($urandom)));
      k++;
      nv = ($urandom_range(0, 15) == 0) ? $urandom_range(100, MAX_VERTICES + 3)
                                          : $urandom_range(0, 8);
      for (int i = 0; i < nv; i++) begin
        send_item(mk(CMD_APPEND, rnd_coord(span), rnd_coord(span), 31'($urandom)));
        k++;
      end
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(0, 7) == 0)
          send_item(mk(CMD_NONE, $urandom, $urandom, 31'($urandom)));
        else if (model_count > 0 && $urandom_range(0, 2) == 0)
          send_item(mk(CMD_QUERY, sb.vx[$urandom_range(0, model_count - 1)],
                       sb.vy[$urandom_range(0, model_count - 1)], rnd_radius()));
        else
          send_item(mk(CMD_QUERY, rnd_coord(span), rnd_coord(span), rnd_radius()));
        k++;
      end
    end
    @(negedge clk);
    in_valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (END_WAIT) @(posedge clk);
    if (sb.n_errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
